[design/y2r_pkg.sv]
package y2r_pkg;

	// Field widths
	localparam int PIX_W   = 8;
	localparam int SIZE_W  = 13;
	localparam int CNT_W   = 12;
	localparam int SUM_W   = 20;
	localparam int PROD_W  = 18;
	localparam int LUMA_PW = 17;

	// Register map
	localparam int APB_ADDR_W = 3;
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [SIZE_W-1:0] MAX_HEIGHT       = 13'd4096;
	localparam int DEFAULT_MAX_WIDTH = 4096;

	// Conversion coefficients
	localparam logic [8:0] LUMA_COEF = 9'd298;
	localparam logic signed [PROD_W-1:0] CR_R_COEF = 18'sd409;
	localparam logic signed [PROD_W-1:0] CB_G_COEF = 18'sd100;
	localparam logic signed [PROD_W-1:0] CR_G_COEF = 18'sd208;
	localparam logic signed [PROD_W-1:0] CB_B_COEF = 18'sd516;
	localparam logic signed [SUM_W-1:0]  ROUND     = 20'sd128;

	// Frame size as written in the registers
	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	// One classified item between front and back
	typedef struct packed {
		logic [PIX_W-1:0] y0;
		logic [PIX_W-1:0] u;
		logic [PIX_W-1:0] y1;
		logic [PIX_W-1:0] v;
		logic             tail;
		logic             row_end;
		logic             frame_end;
	} item_t;

	// Shift and clamp one rounded channel sum to 0..255
	function automatic logic [PIX_W-1:0] sat_u8(input logic signed [SUM_W-1:0] x);
		logic [PIX_W-1:0] res;
		if (x < 0) begin
			res = '0;
		end else if (|x[SUM_W-2:16]) begin
			res = 8'hFF;
		end else begin
			res = x[15:8];
		end
		return res;
	endfunction

endpackage

[design/yuyv_to_rgb_converter.sv]
// YUYV 4:2:2 to RGB888 converter, integer BT.601 studio swing. Each input item is one
// pixel pair (Y0, U, Y1, V) in raster order; each result carries the two RGB pixels,
// a pixel count, a row-end mark on tlast and a frame-end mark on tuser. Frame width
// and height are set through the APB port (width at 0x0, height at 0x4, 13 bits each,
// reset 640 x 480) and should only be written while the stream is idle. The block takes
// one item per clock while the output does not stall; each accepted item is held in the
// two-entry queue after the row/column classifier, then passes the two-stage multiply and
// clamp pipeline. On an odd width the last item of each row yields a single pixel with
// V taken equal to U, and the second pixel's fields are zero.
module yuyv_to_rgb_converter
	import y2r_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// Input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// luma_first, chroma_blue, luma_second, chroma_red
	input  logic [31:0]           s_axis_tdata,
	// Output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// red_first, green_first, blue_first, red_second, green_second, blue_second,
	// pixel_count, 6 bits zero
	output logic [55:0]           m_axis_tdata,
	output logic                  m_axis_tlast,
	// frame_end
	output logic                  m_axis_tuser
);

	cfg_t  cfg_q;
	logic  cfg_wr;
	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;
	logic [6*PIX_W-1:0] out_rgb;
	logic [1:0]         out_count;

	// Register writes
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= FRAME_WIDTH_RST;
			cfg_q.height <= FRAME_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_WIDTH:  cfg_q.width  <= pwdata[SIZE_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.height <= pwdata[SIZE_W-1:0];
				default:          cfg_q        <= cfg_q;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (paddr[2])
			REG_FRAME_WIDTH:  prdata = 32'(cfg_q.width);
			REG_FRAME_HEIGHT: prdata = 32'(cfg_q.height);
			default:          prdata = '0;
		endcase
	end

	y2r_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_data    (s_axis_tdata),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_item  (push_item)
	);

	assign s_axis_tready = push_ready;

	y2r_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	y2r_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_item      (pop_item),
		.pop_ready     (pop_ready),
		.out_valid     (m_axis_tvalid),
		.out_rgb       (out_rgb),
		.out_count     (out_count),
		.out_row_end   (m_axis_tlast),
		.out_frame_end (m_axis_tuser),
		.out_ready     (m_axis_tready)
	);

	assign m_axis_tdata = {6'b000000, out_count, out_rgb};

endmodule

[design/y2r_front.sv]
module y2r_front
	import y2r_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	input  logic [4*PIX_W-1:0]   in_data,
	input  logic                 push_ready,
	output logic                 push_valid,
	output item_t                push_item
);

	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  row_q;
	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic [CNT_W-1:0]  last_col;
	logic [CNT_W-1:0]  last_row;
	logic              row_end;
	logic              frame_end;
	logic              tail;
	logic              accept;

	// Clamp the configured frame size to the supported range
	always_comb begin
		if (cfg.width == '0) begin
			w_eff = SIZE_W'(1);
		end else if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
			w_eff = SIZE_W'(MAX_WIDTH);
		end else begin
			w_eff = cfg.width;
		end
		if (cfg.height == '0) begin
			h_eff = SIZE_W'(1);
		end else if (cfg.height > MAX_HEIGHT) begin
			h_eff = MAX_HEIGHT;
		end else begin
			h_eff = cfg.height;
		end
	end

	// Classify the item by its place in the frame
	assign last_col  = CNT_W'((w_eff - SIZE_W'(1)) >> 1);
	assign last_row  = CNT_W'(h_eff - SIZE_W'(1));
	assign row_end   = (col_q >= last_col);
	assign tail      = row_end & w_eff[0];
	assign frame_end = row_end & (row_q >= last_row);

	assign push_valid = in_valid;
	assign accept     = in_valid & push_ready;

	always_comb begin
		push_item.y0        = in_data[PIX_W-1:0];
		push_item.u         = in_data[2*PIX_W-1:PIX_W];
		push_item.y1        = in_data[3*PIX_W-1:2*PIX_W];
		// On the odd-width tail V takes the value of U
		push_item.v         = tail ? in_data[2*PIX_W-1:PIX_W] : in_data[4*PIX_W-1:3*PIX_W];
		push_item.tail      = tail;
		push_item.row_end   = row_end;
		push_item.frame_end = frame_end;
	end

	// Advance column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

[design/y2r_queue.sv]
module y2r_queue
	import y2r_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop_ready
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/y2r_back.sv]
module y2r_back
	import y2r_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  item_t               pop_item,
	output logic                pop_ready,
	output logic                out_valid,
	output logic [6*PIX_W-1:0]  out_rgb,
	output logic [1:0]          out_count,
	output logic                out_row_end,
	output logic                out_frame_end,
	input  logic                out_ready
);

	logic                     v_s1;
	logic [LUMA_PW-1:0]       yc0_s1;
	logic [LUMA_PW-1:0]       yc1_s1;
	logic signed [PROD_W-1:0] re_s1;
	logic signed [PROD_W-1:0] gd_s1;
	logic signed [PROD_W-1:0] ge_s1;
	logic signed [PROD_W-1:0] bd_s1;
	logic                     tail_s1;
	logic                     row_end_s1;
	logic                     frame_end_s1;

	logic                     v_s2;
	logic [6*PIX_W-1:0]       rgb_s2;
	logic [1:0]               count_s2;
	logic                     row_end_s2;
	logic                     frame_end_s2;

	logic                     ready_s1;
	logic                     ready_s2;
	logic [PIX_W-1:0]         c0;
	logic [PIX_W-1:0]         c1;
	logic signed [8:0]        d;
	logic signed [8:0]        e;
	logic signed [SUM_W-1:0]  l0;
	logic signed [SUM_W-1:0]  l1;
	logic signed [SUM_W-1:0]  r_chr;
	logic signed [SUM_W-1:0]  g_chr;
	logic signed [SUM_W-1:0]  b_chr;
	logic [6*PIX_W-1:0]       rgb;

	// Stage handshakes: each stage moves when the next one has room
	assign ready_s2  = ~v_s2 | out_ready;
	assign ready_s1  = ~v_s1 | ready_s2;
	assign pop_ready = ready_s1;

	// Remove offsets; luma below 16 floors to zero
	assign c0 = (pop_item.y0 > 8'd16) ? pop_item.y0 - 8'd16 : 8'd0;
	assign c1 = (pop_item.y1 > 8'd16) ? pop_item.y1 - 8'd16 : 8'd0;
	assign d  = $signed({1'b0, pop_item.u}) - 9'sd128;
	assign e  = $signed({1'b0, pop_item.v}) - 9'sd128;

	// Stage 1: constant multiplies
	always_ff @(posedge clk) begin
		if (pop_valid & ready_s1) begin
			yc0_s1       <= LUMA_PW'(c0) * LUMA_PW'(LUMA_COEF);
			yc1_s1       <= LUMA_PW'(c1) * LUMA_PW'(LUMA_COEF);
			re_s1        <= PROD_W'(e) * CR_R_COEF;
			gd_s1        <= PROD_W'(d) * CB_G_COEF;
			ge_s1        <= PROD_W'(e) * CR_G_COEF;
			bd_s1        <= PROD_W'(d) * CB_B_COEF;
			tail_s1      <= pop_item.tail;
			row_end_s1   <= pop_item.row_end;
			frame_end_s1 <= pop_item.frame_end;
		end
	end

	// Stage 2: sum, round and clamp both pixels, zeroing the second pixel on the tail
	always_comb begin
		l0    = $signed({3'b000, yc0_s1}) + ROUND;
		l1    = $signed({3'b000, yc1_s1}) + ROUND;
		r_chr = SUM_W'(re_s1);
		g_chr = -SUM_W'(gd_s1) - SUM_W'(ge_s1);
		b_chr = SUM_W'(bd_s1);
		rgb[PIX_W-1:0]         = sat_u8(l0 + r_chr);
		rgb[2*PIX_W-1:PIX_W]   = sat_u8(l0 + g_chr);
		rgb[3*PIX_W-1:2*PIX_W] = sat_u8(l0 + b_chr);
		rgb[4*PIX_W-1:3*PIX_W] = tail_s1 ? '0 : sat_u8(l1 + r_chr);
		rgb[5*PIX_W-1:4*PIX_W] = tail_s1 ? '0 : sat_u8(l1 + g_chr);
		rgb[6*PIX_W-1:5*PIX_W] = tail_s1 ? '0 : sat_u8(l1 + b_chr);
	end

	always_ff @(posedge clk) begin
		if (v_s1 & ready_s2) begin
			rgb_s2       <= rgb;
			count_s2     <= tail_s1 ? 2'd1 : 2'd2;
			row_end_s2   <= row_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	// Hold valid flags per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= pop_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	assign out_valid     = v_s2;
	assign out_rgb       = rgb_s2;
	assign out_count     = count_s2;
	assign out_row_end   = row_end_s2;
	assign out_frame_end = frame_end_s2;

endmodule
